### design/dpqc_pkg.sv
// Package of the DNS query classifier table: request and response payload
// types, action codes, response codes and the default table depth.
// Depends on nothing; every other design file imports it.
package dpqc_pkg;

    localparam int DPQC_TABLE_DEPTH = 32;

    // Disposition of one request.
    typedef enum logic [2:0] {
        ACT_FORMERR = 3'd0,
        ACT_NOTIMP  = 3'd1,
        ACT_REFUSED = 3'd2,
        ACT_FORWARD = 3'd3,
        ACT_DELIVER = 3'd4,
        ACT_DROP    = 3'd5
    } t_action;

    // Response codes written into generated replies.
    localparam logic [2:0] RC_NONE    = 3'd0;
    localparam logic [2:0] RC_FORMERR = 3'd1;
    localparam logic [2:0] RC_NOTIMP  = 3'd4;
    localparam logic [2:0] RC_REFUSED = 3'd5;

    // Request types.
    localparam logic REQ_QUERY  = 1'b0;
    localparam logic REQ_ANSWER = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] txn_id;
        logic        flag_qr;
        logic        flag_z;
        logic        flag_cd;
        logic [15:0] question_count;
        logic [15:0] answer_count;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic        name_blocked;
        logic [15:0] client_port;
        logic [31:0] client_addr;
    } t_req;

    typedef struct packed {
        t_action     action;
        logic [2:0]  rcode;
        logic [15:0] dest_port;
        logic [31:0] dest_addr;
    } t_rsp;

    // One pending transaction as held in the slot memory.
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] port;
        logic [31:0] addr;
    } t_slot;

    // Outcome of classifying a client query.
    typedef struct packed {
        t_rsp rsp;
        logic forward;
    } t_cls;

endpackage

### design/dpqc_if.sv
// Valid/ready channel interfaces for requests and responses of the
// DNS query classifier table. Depends on dpqc_pkg.
interface dpqc_req_if;
    import dpqc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dpqc_rsp_if;
    import dpqc_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/dns_proxy_query_classifier_table.sv
// Pending-transaction table of a filtering DNS forwarder. It takes one request
// at a time and gives exactly one response for each. A client query is
// classified combinationally and its response is registered; a query that
// is forwarded also stores its id, port and address in the next slot of a
// round-robin table held in a synchronous memory. A server answer scans
// that memory from slot 0 upward, one slot per cycle behind a registered
// read, and stops at the first slot whose id matches, or drops the answer
// after the last slot. Each response is held until the output register is
// free and is then handed to it. Slots never written read as id 0, port 0
// and address 0, so an answer with id 0 may hit one; this is tracked by a
// fill count of written slots, so no clearing pass is needed after reset.
// The output register lets a new request be taken while the previous
// response still waits.
// Depends on dpqc_pkg, dpqc_if, dpqc_classify and dpqc_slot_mem.
module dns_proxy_query_classifier_table #(
    parameter int TABLE_DEPTH = dpqc_pkg::DPQC_TABLE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpqc_req_if.sink   i_req,
    dpqc_rsp_if.source o_rsp
);
    import dpqc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_wr_slot, n_wr_slot;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic [15:0]        r_txn_id, n_txn_id;
    t_rsp               r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    t_cls               w_cls;
    logic               w_accept;
    logic               w_out_free;
    logic               w_wr_en;
    t_slot              w_wr_data;
    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    t_slot              w_rd_data;
    t_slot              w_slot;
    logic               w_slot_written;

    dpqc_classify u_classify (
        .i_req (i_req.data),
        .o_cls (w_cls)
    );

    dpqc_slot_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_slot),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_wr_data.id   = i_req.data.txn_id;
    assign w_wr_data.port = i_req.data.client_port;
    assign w_wr_data.addr = i_req.data.client_addr;

    // Slots at or beyond the fill count have never been written and read as
    // all zero, whatever the memory happens to hold.
    assign w_slot_written = CNT_W'(r_cmp_idx) < r_fill;
    assign w_slot         = w_slot_written ? w_rd_data : '0;

    always_comb begin
        n_state     = r_state;
        n_wr_slot   = r_wr_slot;
        n_fill      = r_fill;
        n_cmp_idx   = r_cmp_idx;
        n_txn_id    = r_txn_id;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_cmp_idx;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.data.req_type == REQ_ANSWER) begin
                        // Start the scan with a read of slot 0.
                        n_txn_id  = i_req.data.txn_id;
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_cmp_idx = '0;
                        n_state   = S_SCAN;
                    end else begin
                        n_res = w_cls.rsp;
                        if (w_cls.forward) begin
                            w_wr_en = 1'b1;
                            if (r_wr_slot == IDX_W'(TABLE_DEPTH - 1)) begin
                                n_wr_slot = '0;
                            end else begin
                                n_wr_slot = r_wr_slot + IDX_W'(1);
                            end
                            if (r_fill != CNT_W'(TABLE_DEPTH)) begin
                                n_fill = r_fill + CNT_W'(1);
                            end
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // Read data now belongs to slot r_cmp_idx.
                if (w_slot.id == r_txn_id) begin
                    n_res.action    = ACT_DELIVER;
                    n_res.rcode     = RC_NONE;
                    n_res.dest_port = w_slot.port;
                    n_res.dest_addr = w_slot.addr;
                    n_state         = S_DONE;
                end else if (r_cmp_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_res.action    = ACT_DROP;
                    n_res.rcode     = RC_NONE;
                    n_res.dest_port = 16'd0;
                    n_res.dest_addr = 32'd0;
                    n_state         = S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_cmp_idx + IDX_W'(1);
                    n_cmp_idx = r_cmp_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                // Hand the response over once the output register is free.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_slot   <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_slot   <= n_wr_slot;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_txn_id  <= n_txn_id;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

### design/dpqc_classify.sv
// Header checks for a client query: format error, not implemented, refused
// or forward, in that order of precedence. Depends on dpqc_pkg.
module dpqc_classify (
    input  dpqc_pkg::t_req i_req,
    output dpqc_pkg::t_cls o_cls
);
    import dpqc_pkg::*;

    logic w_formerr;
    logic w_notimp;

    assign w_formerr = i_req.flag_qr || i_req.flag_z || i_req.flag_cd
                    || (i_req.question_count == 16'd0)
                    || (i_req.answer_count != 16'd0)
                    || (i_req.query_type == 16'd0)
                    || (i_req.query_class == 16'd0);
    assign w_notimp  = (i_req.query_type != 16'd1) || (i_req.query_class != 16'd1);

    always_comb begin
        o_cls.forward       = 1'b0;
        o_cls.rsp.dest_port = i_req.client_port;
        o_cls.rsp.dest_addr = i_req.client_addr;
        if (w_formerr) begin
            o_cls.rsp.action = ACT_FORMERR;
            o_cls.rsp.rcode  = RC_FORMERR;
        end else if (w_notimp) begin
            o_cls.rsp.action = ACT_NOTIMP;
            o_cls.rsp.rcode  = RC_NOTIMP;
        end else if (i_req.name_blocked) begin
            o_cls.rsp.action = ACT_REFUSED;
            o_cls.rsp.rcode  = RC_REFUSED;
        end else begin
            // Forwarded queries carry no destination of their own.
            o_cls.forward       = 1'b1;
            o_cls.rsp.action    = ACT_FORWARD;
            o_cls.rsp.rcode     = RC_NONE;
            o_cls.rsp.dest_port = 16'd0;
            o_cls.rsp.dest_addr = 32'd0;
        end
    end

endmodule

### design/dpqc_slot_mem.sv
// Slot memory of the pending-transaction table: one write port, one read
// port with registered read data. Depends on dpqc_pkg.
module dpqc_slot_mem #(
    parameter int TABLE_DEPTH = dpqc_pkg::DPQC_TABLE_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  dpqc_pkg::t_slot     i_wr_data,
    input  logic                i_rd_en,
    input  logic [IDX_W-1:0]    i_rd_addr,
    output dpqc_pkg::t_slot     o_rd_data
);
    import dpqc_pkg::*;

    t_slot r_mem [TABLE_DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### dv/tb_dns_proxy_query_classifier_table.sv
// Self-checking testbench of the DNS query classifier table: a directed table
// of requests, then random traffic, with responses compared against a model.
// Depends on dpqc_pkg, dpqc_if and dns_proxy_query_classifier_table.
module tb_dns_proxy_query_classifier_table;
    timeunit 1ns;
    timeprecision 1ps;

    import dpqc_pkg::*;

    localparam int DEPTH        = DPQC_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 1800;
    localparam int BLOCK_ITEMS  = 150;
    localparam int ID_POOL      = 6;
    // The worst case per request adds a sender gap, a full table scan and a
    // receiver stall; this limit leaves several times the slowest correct run.
    localparam int CYCLE_LIMIT  = 500000;

    // One line of the directed table. Where fixed_rsp is set the expected
    // response is written in the table; otherwise the model supplies it.
    typedef struct {
        t_req req;
        bit   fixed_rsp;
        t_rsp rsp;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dpqc_req_if req_ch ();
    dpqc_rsp_if rsp_ch ();

    dns_proxy_query_classifier_table #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // Model of the pending-transaction table, kept in step with every
    // accepted request.
    logic [15:0] txn_slot_id   [DEPTH];
    logic [15:0] txn_slot_port [DEPTH];
    logic [31:0] txn_slot_addr [DEPTH];
    int          txn_next_slot;

    t_rsp        pending_replies[$];
    int          mismatch_count;
    int          cycle_count;
    bit          idle_on;
    int          rx_stall;
    logic [15:0] id_pool [ID_POOL];

    // Works out the response to one request and updates the slot model. A
    // server answer takes the lowest-numbered slot whose id matches, and slots
    // that were never written still hold id 0, so they can match too.
    function automatic t_rsp resolve_request(t_req r);
        t_rsp res;
        bit   hit;
        res = '{action: ACT_DROP, rcode: RC_NONE, dest_port: '0, dest_addr: '0};
        hit = 1'b0;
        if (r.req_type == REQ_ANSWER) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (!hit && txn_slot_id[i] == r.txn_id) begin
                    hit           = 1'b1;
                    res.action    = ACT_DELIVER;
                    res.dest_port = txn_slot_port[i];
                    res.dest_addr = txn_slot_addr[i];
                end
            end
        end else if (r.flag_qr || r.flag_z || r.flag_cd || r.question_count == 16'd0 ||
                     r.answer_count != 16'd0 || r.query_type == 16'd0 ||
                     r.query_class == 16'd0) begin
            res = '{action: ACT_FORMERR, rcode: RC_FORMERR,
                    dest_port: r.client_port, dest_addr: r.client_addr};
        end else if (r.query_type != 16'd1 || r.query_class != 16'd1) begin
            res = '{action: ACT_NOTIMP, rcode: RC_NOTIMP,
                    dest_port: r.client_port, dest_addr: r.client_addr};
        end else if (r.name_blocked) begin
            res = '{action: ACT_REFUSED, rcode: RC_REFUSED,
                    dest_port: r.client_port, dest_addr: r.client_addr};
        end else begin
            // Forwarded: remember the client in the next round-robin slot.
            txn_slot_id[txn_next_slot]   = r.txn_id;
            txn_slot_port[txn_next_slot] = r.client_port;
            txn_slot_addr[txn_next_slot] = r.client_addr;
            txn_next_slot = (txn_next_slot == DEPTH - 1) ? 0 : txn_next_slot + 1;
            res.action = ACT_FORWARD;
        end
        return res;
    endfunction

    function automatic t_req build_query(logic [15:0] id, logic qr, logic z, logic cd,
                                         logic [15:0] qd, logic [15:0] an,
                                         logic [15:0] qtype, logic [15:0] qclass,
                                         logic blocked, logic [15:0] port,
                                         logic [31:0] addr);
        t_req r;
        r.req_type       = REQ_QUERY;
        r.txn_id         = id;
        r.flag_qr        = qr;
        r.flag_z         = z;
        r.flag_cd        = cd;
        r.question_count = qd;
        r.answer_count   = an;
        r.query_type     = qtype;
        r.query_class    = qclass;
        r.name_blocked   = blocked;
        r.client_port    = port;
        r.client_addr    = addr;
        return r;
    endfunction

    function automatic t_req build_answer(logic [15:0] id);
        t_req r;
        r          = '0;
        r.req_type = REQ_ANSWER;
        r.txn_id   = id;
        return r;
    endfunction

    function automatic t_stim_row fixed_row(t_req r, t_action act, logic [2:0] rc,
                                            logic [15:0] port, logic [31:0] addr);
        t_stim_row row;
        row.req       = r;
        row.fixed_rsp = 1'b1;
        row.rsp       = '{action: act, rcode: rc, dest_port: port, dest_addr: addr};
        return row;
    endfunction

    function automatic t_stim_row open_row(t_req r);
        t_stim_row row;
        row.req       = r;
        row.fixed_rsp = 1'b0;
        row.rsp       = '0;
        return row;
    endfunction

    // Most ids come from a small pool so that answers find their queries and
    // slots get overwritten; the rest are spread over the full range.
    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 9) < 8)
            return id_pool[$urandom_range(0, ID_POOL - 1)];
        return 16'($urandom());
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   kind;
        int   flaw;
        kind = $urandom_range(0, 99);
        // Start from a well-formed query that would be forwarded.
        r = build_query(pick_id(), 1'b0, 1'b0, 1'b0,
                        ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) : 16'd1,
                        16'd0, 16'd1, 16'd1, 1'b0, 16'($urandom()), $urandom());
        if (kind < 40) begin
            // forwarded query, nothing to change
        end else if (kind < 70) begin
            // Server answer: only the id matters, the rest is noise.
            r          = t_req'({4'($urandom()), $urandom(), $urandom(), $urandom(),
                                 $urandom()});
            r.req_type = REQ_ANSWER;
            r.txn_id   = pick_id();
        end else if (kind < 78) begin
            r.name_blocked = 1'b1;
        end else if (kind < 88) begin
            r.query_type  = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom_range(1, 65535));
            r.query_class = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom_range(1, 65535));
            if (r.query_type == 16'd1 && r.query_class == 16'd1)
                r.query_type = 16'($urandom_range(2, 65535));
            r.name_blocked = 1'($urandom());
        end else if (kind < 96) begin
            // Break exactly one of the format rules.
            flaw = $urandom_range(0, 6);
            case (flaw)
                0: r.flag_qr        = 1'b1;
                1: r.flag_z         = 1'b1;
                2: r.flag_cd        = 1'b1;
                3: r.question_count = 16'd0;
                4: r.answer_count   = 16'($urandom_range(1, 65535));
                5: r.query_type     = 16'd0;
                default: r.query_class = 16'd0;
            endcase
            r.name_blocked = 1'($urandom());
        end else begin
            r          = t_req'({4'($urandom()), $urandom(), $urandom(), $urandom(),
                                 $urandom()});
            r.req_type = REQ_QUERY;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Presents one request at the falling edge after a random gap (none when idling is off),
    // holds it until it is taken, and records what the block should answer.
    task automatic send_request(t_stim_row row);
        int   gap;
        t_rsp predicted;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= row.req;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        // The model always runs so that its slot table stays in step, even
        // where the table row gives the response outright.
        predicted = resolve_request(row.req);
        pending_replies.push_back(row.fixed_rsp ? row.rsp : predicted);
    endtask

    // Holds off new requests until every response has come back.
    task automatic drain_replies();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Response side: ready is changed at the falling edge, with a random
    // number of stall cycles drawn after each response when idling is on.
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("response with no request outstanding, action %0d",
                                          got.action));
            end else begin
                want = pending_replies.pop_front();
                if (got.action !== want.action)
                    report_mismatch($sformatf("action %0d, expected %0d",
                                              got.action, want.action));
                if (got.rcode !== want.rcode)
                    report_mismatch($sformatf("rcode %0d, expected %0d",
                                              got.rcode, want.rcode));
                if (got.dest_port !== want.dest_port)
                    report_mismatch($sformatf("dest_port %h, expected %h",
                                              got.dest_port, want.dest_port));
                if (got.dest_addr !== want.dest_addr)
                    report_mismatch($sformatf("dest_addr %h, expected %h",
                                              got.dest_addr, want.dest_addr));
            end
            rx_stall = idle_on ? $urandom_range(0, 4) : 0;
        end
    end

    initial begin
        t_stim_row directed_rows[$];
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        rx_stall       = 0;
        idle_on        = 1'b1;
        mismatch_count = 0;
        cycle_count    = 0;
        txn_next_slot  = 0;
        for (int i = 0; i < DEPTH; i++) begin
            txn_slot_id[i]   = '0;
            txn_slot_port[i] = '0;
            txn_slot_addr[i] = '0;
        end

        // Right after reset every slot is empty with id 0: an answer with id 0
        // is delivered to port 0, address 0, and any other id is dropped.
        directed_rows.push_back(fixed_row(build_answer(16'h0000),
                                          ACT_DELIVER, RC_NONE, 16'h0, 32'h0));
        directed_rows.push_back(fixed_row(build_answer(16'hFFFF),
                                          ACT_DROP, RC_NONE, 16'h0, 32'h0));
        // Each format rule on its own; replies go back to the querying client.
        directed_rows.push_back(fixed_row(
            build_query(16'h0101, 1'b1, 1'b0, 1'b0, 16'd1, 16'd0, 16'd1, 16'd1,
                        1'b0, 16'h0, 32'h0),
            ACT_FORMERR, RC_FORMERR, 16'h0, 32'h0));
        directed_rows.push_back(fixed_row(
            build_query(16'h0102, 1'b0, 1'b1, 1'b0, 16'd1, 16'd0, 16'd1, 16'd1,
                        1'b0, 16'hFFFF, 32'hFFFFFFFF),
            ACT_FORMERR, RC_FORMERR, 16'hFFFF, 32'hFFFFFFFF));
        directed_rows.push_back(fixed_row(
            build_query(16'h0103, 1'b0, 1'b0, 1'b1, 16'd1, 16'd0, 16'd1, 16'd1,
                        1'b0, 16'h1111, 32'h01020304),
            ACT_FORMERR, RC_FORMERR, 16'h1111, 32'h01020304));
        directed_rows.push_back(fixed_row(
            build_query(16'h0104, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd1, 16'd1,
                        1'b0, 16'h2222, 32'h0A000001),
            ACT_FORMERR, RC_FORMERR, 16'h2222, 32'h0A000001));
        directed_rows.push_back(fixed_row(
            build_query(16'h0105, 1'b0, 1'b0, 1'b0, 16'd1, 16'hFFFF, 16'd1, 16'd1,
                        1'b0, 16'h3333, 32'hC0A80001),
            ACT_FORMERR, RC_FORMERR, 16'h3333, 32'hC0A80001));
        directed_rows.push_back(fixed_row(
            build_query(16'h0106, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd0, 16'd1,
                        1'b1, 16'h4444, 32'h7F000001),
            ACT_FORMERR, RC_FORMERR, 16'h4444, 32'h7F000001));
        directed_rows.push_back(fixed_row(
            build_query(16'h0107, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd1, 16'd0,
                        1'b0, 16'h5555, 32'h80000000),
            ACT_FORMERR, RC_FORMERR, 16'h5555, 32'h80000000));
        // Valid format but a type or class other than 1.
        directed_rows.push_back(fixed_row(
            build_query(16'h0108, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 16'hFFFF, 16'd1,
                        1'b0, 16'h6666, 32'h0),
            ACT_NOTIMP, RC_NOTIMP, 16'h6666, 32'h0));
        directed_rows.push_back(fixed_row(
            build_query(16'h0109, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd1, 16'hFFFF,
                        1'b1, 16'h7777, 32'h1),
            ACT_NOTIMP, RC_NOTIMP, 16'h7777, 32'h1));
        directed_rows.push_back(fixed_row(
            build_query(16'h010A, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd28, 16'd255,
                        1'b0, 16'h8888, 32'h2),
            ACT_NOTIMP, RC_NOTIMP, 16'h8888, 32'h2));
        directed_rows.push_back(fixed_row(
            build_query(16'h010B, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd1, 16'd1,
                        1'b1, 16'h9999, 32'hDEADBEEF),
            ACT_REFUSED, RC_REFUSED, 16'h9999, 32'hDEADBEEF));
        // Forwards with the field extremes, then answers that look them up.
        directed_rows.push_back(fixed_row(
            build_query(16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd1, 16'd1,
                        1'b0, 16'hFFFF, 32'hFFFFFFFF),
            ACT_FORWARD, RC_NONE, 16'h0, 32'h0));
        directed_rows.push_back(open_row(build_answer(16'hFFFF)));
        directed_rows.push_back(open_row(
            build_query(16'h0000, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd1, 16'd1,
                        1'b0, 16'h1234, 32'h12345678)));
        directed_rows.push_back(open_row(build_answer(16'h0000)));
        directed_rows.push_back(fixed_row(
            build_query(16'h0001, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'd0, 16'd1, 16'd1,
                        1'b0, 16'h0000, 32'h0),
            ACT_FORWARD, RC_NONE, 16'h0, 32'h0));
        directed_rows.push_back(open_row(build_answer(16'h0001)));
        directed_rows.push_back(open_row(build_answer(16'h5555)));
        // A repeated id: the answer must find the lower-numbered slot.
        directed_rows.push_back(open_row(
            build_query(16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd1, 16'd1,
                        1'b0, 16'hABCD, 32'h0BADF00D)));
        directed_rows.push_back(open_row(build_answer(16'hFFFF)));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        drain_replies();

        // Random traffic in blocks; each block has its own id pool and either
        // random idling or none, and ends by letting the block run dry.
        for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < ID_POOL; k++)
                id_pool[k] = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom());
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send_request(open_row(random_request()));
            drain_replies();
        end

        // Nothing is expected any more; allow one more full table scan.
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
